### rtl/uws_pkg.sv
// ----------------------------------------------------------------------------
// uws_pkg
// Shared types, code point constants and helpers for the utf-8 word splitter.
// ----------------------------------------------------------------------------
package uws_pkg;

  // default depth of the queue between front and back
  localparam int unsigned QUEUE_DEPTH = 4;

  localparam int unsigned CP_W   = 31;
  localparam int unsigned BYTE_W = 7;

  // code points with a fixed ascii rewrite
  localparam logic [CP_W-1:0] CP_EN_DASH  = 31'h0000_2013;
  localparam logic [CP_W-1:0] CP_HOR_BAR  = 31'h0000_2015;
  localparam logic [CP_W-1:0] CP_AE_SMALL = 31'h0000_00e6;
  localparam logic [CP_W-1:0] CP_AE_CAP   = 31'h0000_00c6;

  // ascii characters that appear on the output
  localparam logic [BYTE_W-1:0] CH_NEWLINE = 7'h0a;
  localparam logic [BYTE_W-1:0] CH_HYPHEN  = 7'h2d;
  localparam logic [BYTE_W-1:0] CH_APOS    = 7'h27;
  localparam logic [BYTE_W-1:0] CH_LOW_A   = 7'h61;
  localparam logic [BYTE_W-1:0] CH_LOW_E   = 7'h65;
  localparam logic [BYTE_W-1:0] CH_LOW_Z   = 7'h7a;
  localparam logic [BYTE_W-1:0] CH_UP_A    = 7'h41;
  localparam logic [BYTE_W-1:0] CH_UP_Z    = 7'h5a;
  localparam logic [BYTE_W-1:0] CH_DIG_0   = 7'h30;
  localparam logic [BYTE_W-1:0] CH_DIG_9   = 7'h39;

  typedef enum logic {
    KIND_TEXT   = 1'b0,
    KIND_REPORT = 1'b1
  } kind_e;

  // one queued command: one or two results, the second always a text byte
  typedef struct packed {
    logic                two;
    kind_e               r0_kind;
    logic [BYTE_W-1:0]   r0_byte;
    logic [CP_W-1:0]     r0_cp;
    logic [BYTE_W-1:0]   r1_byte;
  } cmd_t;

  // letters, digits, apostrophe and hyphen
  function automatic logic is_word_char(input logic [BYTE_W-1:0] c);
    return (c >= CH_LOW_A && c <= CH_LOW_Z) || (c >= CH_UP_A && c <= CH_UP_Z) ||
           (c >= CH_DIG_0 && c <= CH_DIG_9) || (c == CH_APOS) || (c == CH_HYPHEN);
  endfunction

endpackage

### rtl/uws_in_if.sv
// ----------------------------------------------------------------------------
// uws_in_if
// Input channel: one raw byte or an end of stream marker per transaction.
// ----------------------------------------------------------------------------
interface uws_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_stream;

  modport source (output valid, output in_byte, output end_of_stream, input ready);
  modport sink   (input valid, input in_byte, input end_of_stream, output ready);
endinterface

### rtl/uws_out_if.sv
// ----------------------------------------------------------------------------
// uws_out_if
// Output channel: one text byte or one symbol report per transaction.
// ----------------------------------------------------------------------------
interface uws_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [6:0]  out_byte;
  logic [30:0] code_point;
  logic        last;

  modport source (output valid, output kind, output out_byte, output code_point,
                  output last, input ready);
  modport sink   (input valid, input kind, input out_byte, input code_point,
                  input last, output ready);
endinterface

### rtl/uws_front.sv
// ----------------------------------------------------------------------------
// uws_front
// Decodes utf-8 bytes into code points, keeps word state and builds commands.
// ----------------------------------------------------------------------------
module uws_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  uws_in_if.sink        in_i,
  output logic          push_valid_o,
  output uws_pkg::cmd_t push_cmd_o,
  input  logic          push_ready_i
);

  logic [uws_pkg::CP_W-1:0] partial_q, partial_d;
  logic [2:0]               rem_q, rem_d;
  logic                     in_word_q, in_word_d;

  logic                     accept;
  logic                     have_code;
  logic                     end_word;
  logic [uws_pkg::CP_W-1:0] code;
  logic [uws_pkg::CP_W-1:0] next_code;
  logic [1:0]               n_res;
  uws_pkg::cmd_t            cmd;

  assign next_code = {partial_q[uws_pkg::CP_W-7:0], in_i.in_byte[5:0]};

  // byte decode, code point handling and result assembly
  always_comb begin
    partial_d = partial_q;
    rem_d     = rem_q;
    in_word_d = in_word_q;
    have_code = 1'b0;
    end_word  = 1'b0;
    code      = '0;
    n_res     = 2'd0;
    cmd       = '0;

    if (in_i.end_of_stream) begin
      end_word  = 1'b1;
      partial_d = '0;
      rem_d     = 3'd0;
    end else if (rem_q != 3'd0) begin
      rem_d = rem_q - 3'd1;
      if (rem_q == 3'd1) begin
        have_code = 1'b1;
        code      = next_code;
        partial_d = '0;
      end else begin
        partial_d = next_code;
      end
    end else if (!in_i.in_byte[7]) begin
      have_code = 1'b1;
      code      = {24'd0, in_i.in_byte[6:0]};
    end else if (!in_i.in_byte[6] || (in_i.in_byte[7:1] == 7'h7f)) begin
      // stray continuation or 0xfe / 0xff
      end_word = 1'b1;
    end else if (!in_i.in_byte[5]) begin
      rem_d     = 3'd1;
      partial_d = {26'd0, in_i.in_byte[4:0]};
    end else if (!in_i.in_byte[4]) begin
      rem_d     = 3'd2;
      partial_d = {27'd0, in_i.in_byte[3:0]};
    end else if (!in_i.in_byte[3]) begin
      rem_d     = 3'd3;
      partial_d = {28'd0, in_i.in_byte[2:0]};
    end else if (!in_i.in_byte[2]) begin
      rem_d     = 3'd4;
      partial_d = {29'd0, in_i.in_byte[1:0]};
    end else begin
      rem_d     = 3'd5;
      partial_d = {30'd0, in_i.in_byte[0]};
    end

    if (have_code) begin
      if (code == uws_pkg::CP_EN_DASH) begin
        n_res       = 2'd1;
        cmd.r0_byte = uws_pkg::CH_HYPHEN;
      end else if (code == uws_pkg::CP_HOR_BAR) begin
        n_res       = 2'd2;
        cmd.r0_byte = uws_pkg::CH_HYPHEN;
        cmd.r1_byte = uws_pkg::CH_HYPHEN;
      end else if (code == uws_pkg::CP_AE_SMALL) begin
        n_res       = 2'd2;
        cmd.r0_byte = uws_pkg::CH_LOW_A;
        cmd.r1_byte = uws_pkg::CH_LOW_E;
      end else if (code == uws_pkg::CP_AE_CAP) begin
        n_res       = 2'd2;
        cmd.r0_byte = uws_pkg::CH_UP_A;
        cmd.r1_byte = uws_pkg::CH_LOW_E;
      end else if ((code[uws_pkg::CP_W-1:7] == '0) && uws_pkg::is_word_char(code[6:0])) begin
        n_res       = 2'd1;
        cmd.r0_byte = code[6:0];
        in_word_d   = 1'b1;
      end else begin
        if (code[uws_pkg::CP_W-1:7] != '0) begin
          n_res       = 2'd1;
          cmd.r0_kind = uws_pkg::KIND_REPORT;
          cmd.r0_cp   = code;
        end
        end_word = 1'b1;
      end
    end

    // close an open word
    if (end_word && in_word_q) begin
      in_word_d = 1'b0;
      if (n_res == 2'd0) begin
        cmd.r0_byte = uws_pkg::CH_NEWLINE;
        n_res       = 2'd1;
      end else begin
        cmd.r1_byte = uws_pkg::CH_NEWLINE;
        n_res       = 2'd2;
      end
    end

    cmd.two = (n_res == 2'd2);
  end

  assign accept       = in_i.valid && push_ready_i;
  assign in_i.ready   = push_ready_i;
  assign push_valid_o = in_i.valid && (n_res != 2'd0);
  assign push_cmd_o   = cmd;

  // decoder state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      partial_q <= '0;
      rem_q     <= 3'd0;
      in_word_q <= 1'b0;
    end else if (accept) begin
      partial_q <= partial_d;
      rem_q     <= rem_d;
      in_word_q <= in_word_d;
    end
  end

`ifndef SYNTHESIS
  // never more than five continuation bytes outstanding
  assert property (@(posedge clk_i) disable iff (!rst_ni) rem_q <= 3'd5)
    else $error("continuation count out of range");

  // end of stream leaves the decoder and word state cleared
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   accept && in_i.end_of_stream |=> (rem_q == 3'd0) && !in_word_q)
    else $error("state not cleared after end of stream");

  // no partial code is held outside a sequence
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (rem_q == 3'd0) |-> (partial_q == '0))
    else $error("partial code left over outside a sequence");
`endif

endmodule

### rtl/uws_queue.sv
// ----------------------------------------------------------------------------
// uws_queue
// Short command queue that decouples the decoder from the result sequencer.
// ----------------------------------------------------------------------------
module uws_queue #(
  parameter int unsigned DEPTH = uws_pkg::QUEUE_DEPTH
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  uws_pkg::cmd_t push_cmd_i,
  output logic          pop_valid_o,
  input  logic          pop_ready_i,
  output uws_pkg::cmd_t pop_cmd_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  uws_pkg::cmd_t    mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;
  logic             push, pop;

  assign push_ready_o = (count_q != FULL_CNT);
  assign pop_valid_o  = (count_q != '0);
  assign pop_cmd_o    = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= FULL_CNT)
    else $error("queue fill level overflow");

  // pointers agree with the fill level when empty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (count_q == '0) |-> (wr_ptr_q == rd_ptr_q))
    else $error("queue pointers disagree while empty");

  // a lone pop from a single entry empties the queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (count_q == CNT_W'(1)) && pop && !push |=> !pop_valid_o)
    else $error("queue not empty after last pop");
`endif

endmodule

### rtl/uws_back.sv
// ----------------------------------------------------------------------------
// uws_back
// Plays out each queued command as one or two results on the output channel.
// ----------------------------------------------------------------------------
module uws_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          pop_valid_i,
  output logic          pop_ready_o,
  input  uws_pkg::cmd_t pop_cmd_i,
  uws_out_if.source     out_o
);

  logic                       out_valid_q;
  logic                       pend_q;
  logic [uws_pkg::BYTE_W-1:0] pend_byte_q;
  uws_pkg::kind_e             kind_q;
  logic [uws_pkg::BYTE_W-1:0] byte_q;
  logic [uws_pkg::CP_W-1:0]   cp_q;
  logic                       last_q;
  logic                       out_fire;
  logic                       pop;

  assign out_fire    = out_valid_q && out_o.ready;
  assign pop_ready_o = !out_valid_q || (out_o.ready && !pend_q);
  assign pop         = pop_valid_i && pop_ready_o;

  // control: output valid and second-result pending
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      pend_q      <= 1'b0;
    end else if (pop) begin
      out_valid_q <= 1'b1;
      pend_q      <= pop_cmd_i.two;
    end else if (out_fire && pend_q) begin
      pend_q      <= 1'b0;
    end else if (out_fire) begin
      out_valid_q <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (pop) begin
      kind_q      <= pop_cmd_i.r0_kind;
      byte_q      <= pop_cmd_i.r0_byte;
      cp_q        <= pop_cmd_i.r0_cp;
      last_q      <= !pop_cmd_i.two;
      pend_byte_q <= pop_cmd_i.r1_byte;
    end else if (out_fire && pend_q) begin
      kind_q <= uws_pkg::KIND_TEXT;
      byte_q <= pend_byte_q;
      cp_q   <= '0;
      last_q <= 1'b1;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.kind       = kind_q;
  assign out_o.out_byte   = byte_q;
  assign out_o.code_point = cp_q;
  assign out_o.last       = last_q;

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni) pend_q |-> out_valid_q)
    else $error("second result pending without a shown result");

  // the first of a pair is never marked last
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   out_valid_q && pend_q |-> !last_q)
    else $error("first of two results marked last");

  // a report carries no text byte, a text byte carries no code point
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   out_valid_q |-> ((kind_q == uws_pkg::KIND_REPORT) ? (byte_q == '0)
                                                                    : (cp_q == '0)))
    else $error("result fields inconsistent with kind");
`endif

endmodule

### rtl/utf8_word_splitter_unit.sv
// ----------------------------------------------------------------------------
// utf8_word_splitter_unit
// UTF-8 decoder and word tokeniser with ascii rewrites and symbol reports.
// ----------------------------------------------------------------------------
// One input transaction is taken per cycle while the command queue has room.
// Each byte gives zero, one or two results, and results leave at one per
// cycle from the output register while the output channel is ready. A byte
// gives two results for the horizontal bar, the ae ligatures, or a report
// followed by the newline that ends a word. The sustained rate is therefore
// set by the output register; the queue of QUEUE_DEPTH commands absorbs
// bursts and lets the input keep flowing while the output is stalled. The
// command for an input transaction passes through the queue and then the
// output register before its first result appears. The last flag marks
// the final result caused by each input byte.
// ----------------------------------------------------------------------------
module utf8_word_splitter_unit #(
  parameter int unsigned QUEUE_DEPTH = uws_pkg::QUEUE_DEPTH
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  uws_in_if.sink    in_i,
  uws_out_if.source out_o
);

  logic          push_valid, push_ready;
  uws_pkg::cmd_t push_cmd;
  logic          pop_valid, pop_ready;
  uws_pkg::cmd_t pop_cmd;

  // byte decode and word state
  uws_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .push_valid_o (push_valid),
    .push_cmd_o   (push_cmd),
    .push_ready_i (push_ready)
  );

  // command queue
  uws_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_cmd_i   (push_cmd),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_cmd_o    (pop_cmd)
  );

  // result sequencing
  uws_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_cmd_i   (pop_cmd),
    .out_o       (out_o)
  );

endmodule
